[hdl/hlc_pkg.sv]
// Shared types, constants and helpers of the hand landmark canonicalizer.
// No dependencies; every other file but hlc_stream_if refers to it by scoped names.
package hlc_pkg;

    localparam int COORD_W         = 20;
    localparam int COORD_FRAC_BITS = 16;
    localparam int DIM_W           = 16;
    localparam int MAX_POINTS_DEF  = 32;

    // epsilon is 1e-5 rounded to an LSB, never below one LSB
    localparam int EPS_RAW = ((1 << COORD_FRAC_BITS) + 50000) / 100000;
    localparam int EPS     = (EPS_RAW < 1) ? 1 : EPS_RAW;

    // signed dividend width: aspect product (21 x 17 bits) or coordinate << frac
    localparam int DIV_NW = (38 > COORD_W + COORD_FRAC_BITS) ? 38 : COORD_W + COORD_FRAC_BITS;
    // divisor width: coordinate range plus epsilon, or the larger image dimension
    localparam int DIV_DW = COORD_W + 1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_ASPECT_EN = 2'd0,
        CFG_IMG_W     = 2'd1,
        CFG_IMG_H     = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        DS_ASP_X = 3'd0,
        DS_ASP_Y = 3'd1,
        DS_OUT_X = 3'd2,
        DS_OUT_Y = 3'd3,
        DS_OUT_Z = 3'd4
    } t_dsel;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
        logic                      end_of_hand;
        logic [1:0]                status;
    } t_out_item;

    typedef struct packed {
        logic  cap_in;
        logic  div_start;
        t_dsel div_sel;
        logic  store_pt;
        logic  latch_scale;
        logic  mem_rd;
        logic  load_ok;
        logic  load_err;
        logic  idx_inc;
        logic  clear_hand;
    } t_cmd;

    typedef struct packed {
        logic    do_aspect;
        logic    last;
        logic    div_done;
        t_status err;
        logic    emit_last;
        logic    out_free;
    } t_sts;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [DIV_NW:0] v);
        logic signed [DIV_NW:0] hi;
        logic signed [DIV_NW:0] lo;
        hi = (DIV_NW+1)'(COORD_MAX);
        lo = (DIV_NW+1)'(COORD_MIN);
        if (v > hi) begin
            sat_coord = COORD_MAX;
        end else if (v < lo) begin
            sat_coord = COORD_MIN;
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

[hdl/hlc_stream_if.sv]
// Valid/ready stream channel carrying one item of type T.
// Depends on nothing; payload types come from hlc_pkg at the instance.
interface hlc_stream_if #(
    parameter type T = logic
) (
    input logic i_clk
);
    logic valid;
    logic ready;
    T     data;

    modport source (input i_clk, input ready, output valid, output data);
    modport sink   (input i_clk, input valid, input data, output ready);
endinterface

[hdl/hlc_div.sv]
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on hlc_pkg for widths.
module hlc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [hlc_pkg::DIV_NW-1:0] i_num,
    input  logic [hlc_pkg::DIV_DW-1:0]        i_den,
    output logic                              o_done,
    output logic signed [hlc_pkg::DIV_NW:0]   o_quo
);
    localparam int NW   = hlc_pkg::DIV_NW;
    localparam int DW   = hlc_pkg::DIV_DW;
    localparam int CN_W = $clog2(NW + 1);

    logic            r_busy, r_done, r_neg;
    logic [CN_W-1:0] r_cnt;
    logic [NW-1:0]   r_q;
    logic [DW:0]     r_rem;
    logic [DW-1:0]   r_den;
    logic [DW:0]     w_sh;
    logic            w_ge;

    assign w_sh = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CN_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NW-1];
            r_q   <= i_num[NW-1] ? (~i_num + 1'b1) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= w_sh - {1'b0, r_den};
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
endmodule

[hdl/hlc_ctrl.sv]
// Sequencer of the canonicalizer: capture, aspect divides, store, then emit loop or error item.
// Depends on hlc_pkg for the command and status structs.
module hlc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hlc_pkg::t_sts i_sts,
    output hlc_pkg::t_cmd o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PREP  = 12'b0000_0000_0010,
        S_AX    = 12'b0000_0000_0100,
        S_AY    = 12'b0000_0000_1000,
        S_STORE = 12'b0000_0001_0000,
        S_FIN   = 12'b0000_0010_0000,
        S_ERR   = 12'b0000_0100_0000,
        S_RD    = 12'b0000_1000_0000,
        S_LAT   = 12'b0001_0000_0000,
        S_DX    = 12'b0010_0000_0000,
        S_DY    = 12'b0100_0000_0000,
        S_DZ    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_push, n_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_push  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_push  <= n_push;
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_push;

    always_comb begin
        n_state = r_state;
        n_push  = r_push;
        o_cmd   = '0;
        o_cmd.div_sel = hlc_pkg::DS_ASP_X;
        if (r_push) begin
            // result of the current point waits for the output register
            if (i_sts.out_free) begin
                o_cmd.load_ok = 1'b1;
                n_push        = 1'b0;
                if (i_sts.emit_last) begin
                    o_cmd.clear_hand = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_RD;
                end
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.cap_in = 1'b1;
                        n_state      = S_PREP;
                    end
                end
                S_PREP: begin
                    if (i_sts.do_aspect) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = hlc_pkg::DS_ASP_X;
                        n_state         = S_AX;
                    end else begin
                        n_state = S_STORE;
                    end
                end
                S_AX: begin
                    if (i_sts.div_done) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = hlc_pkg::DS_ASP_Y;
                        n_state         = S_AY;
                    end
                end
                S_AY: begin
                    if (i_sts.div_done) begin
                        n_state = S_STORE;
                    end
                end
                S_STORE: begin
                    o_cmd.store_pt = 1'b1;
                    n_state        = i_sts.last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    if (i_sts.err != hlc_pkg::ST_OK) begin
                        n_state = S_ERR;
                    end else begin
                        o_cmd.latch_scale = 1'b1;
                        n_state           = S_RD;
                    end
                end
                S_ERR: begin
                    if (i_sts.out_free) begin
                        o_cmd.load_err   = 1'b1;
                        o_cmd.clear_hand = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
                S_RD: begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_LAT;
                end
                S_LAT: begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = hlc_pkg::DS_OUT_X;
                    n_state         = S_DX;
                end
                S_DX: begin
                    if (i_sts.div_done) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = hlc_pkg::DS_OUT_Y;
                        n_state         = S_DY;
                    end
                end
                S_DY: begin
                    if (i_sts.div_done) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = hlc_pkg::DS_OUT_Z;
                        n_state         = S_DZ;
                    end
                end
                S_DZ: begin
                    if (i_sts.div_done) begin
                        n_push  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end
endmodule

[hdl/hlc_datapath.sv]
// Datapath: config registers, point store, min/max tracking, divider, output register.
// Depends on hlc_pkg and hlc_div.
module hlc_datapath #(
    parameter int MAX_POINTS = hlc_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [hlc_pkg::DIM_W-1:0]    i_cfg_wdata,
    input  hlc_pkg::t_in_item            i_item,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output hlc_pkg::t_out_item           o_out_item,
    input  hlc_pkg::t_cmd                i_cmd,
    output hlc_pkg::t_sts                o_sts
);
    localparam int CW    = hlc_pkg::COORD_W;
    localparam int NW    = hlc_pkg::DIV_NW;
    localparam int DW    = hlc_pkg::DIV_DW;
    localparam int FRAC  = hlc_pkg::COORD_FRAC_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic signed [CW:0]  HALF   = (CW+1)'(1 << (FRAC - 1));
    localparam logic signed [NW:0]  HALF_Q = (NW+1)'(1 << (FRAC - 1));

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_pt;

    // configuration
    logic                      r_asp_en;
    logic [hlc_pkg::DIM_W-1:0] r_img_w, r_img_h;

    // current point and hand state
    t_pt                  r_pt;
    logic                 r_last, r_do_asp, r_bad;
    t_pt                  r_wrist;
    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [CNT_W-1:0]     r_cnt, r_idx;
    logic                 r_ovf;
    logic [DW-1:0]        r_scale;
    t_pt                  r_mem [MAX_POINTS];
    t_pt                  r_rd;
    logic signed [CW-1:0] r_nx, r_ny;
    hlc_pkg::t_dsel       r_sel;

    logic                      r_ov;
    hlc_pkg::t_out_item        r_out;

    logic [hlc_pkg::DIM_W-1:0] w_maxdim;
    logic signed [NW-1:0]      w_num;
    logic [DW-1:0]             w_den;
    logic                      w_done;
    logic signed [NW:0]        w_quo;
    logic signed [CW-1:0]      w_q_sat, w_a_sat;
    t_pt                       w_wr, w_diff;
    logic signed [CW:0]        w_rx, w_ry;
    hlc_pkg::t_status          w_err;

    assign w_maxdim = (r_img_w > r_img_h) ? r_img_w : r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asp_en <= 1'b0;
            r_img_w  <= hlc_pkg::DIM_W'(1);
            r_img_h  <= hlc_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (hlc_pkg::t_cfg_idx'(i_cfg_idx))
                hlc_pkg::CFG_ASPECT_EN: r_asp_en <= i_cfg_wdata[0];
                hlc_pkg::CFG_IMG_W:     r_img_w  <= i_cfg_wdata;
                hlc_pkg::CFG_IMG_H:     r_img_h  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // divider operands; the aspect product is registered inside the divider
    always_comb begin
        unique case (i_cmd.div_sel)
            hlc_pkg::DS_ASP_X: begin
                w_num = NW'(($signed({r_pt.x[CW-1], r_pt.x}) - HALF)
                            * $signed({1'b0, r_img_w}));
                w_den = DW'(w_maxdim);
            end
            hlc_pkg::DS_ASP_Y: begin
                w_num = NW'(($signed({r_pt.y[CW-1], r_pt.y}) - HALF)
                            * $signed({1'b0, r_img_h}));
                w_den = DW'(w_maxdim);
            end
            hlc_pkg::DS_OUT_X: begin
                w_num = NW'($signed(r_rd.x)) <<< FRAC;
                w_den = r_scale;
            end
            hlc_pkg::DS_OUT_Y: begin
                w_num = NW'($signed(r_rd.y)) <<< FRAC;
                w_den = r_scale;
            end
            default: begin
                w_num = NW'($signed(r_rd.z)) <<< FRAC;
                w_den = r_scale;
            end
        endcase
    end

    hlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quo   (w_quo)
    );

    assign w_q_sat = hlc_pkg::sat_coord(w_quo);
    assign w_a_sat = hlc_pkg::sat_coord(w_quo + HALF_Q);

    // first point of a hand is its own wrist
    assign w_wr = (r_cnt == '0) ? r_pt : r_wrist;
    assign w_diff.x = hlc_pkg::sat_coord((NW+1)'($signed(r_pt.x)) - (NW+1)'($signed(w_wr.x)));
    assign w_diff.y = hlc_pkg::sat_coord((NW+1)'($signed(r_pt.y)) - (NW+1)'($signed(w_wr.y)));
    assign w_diff.z = hlc_pkg::sat_coord((NW+1)'($signed(r_pt.z)) - (NW+1)'($signed(w_wr.z)));

    // min <= 0 <= max, so both ranges are non-negative
    assign w_rx = $signed({r_max_x[CW-1], r_max_x}) - $signed({r_min_x[CW-1], r_min_x});
    assign w_ry = $signed({r_max_y[CW-1], r_max_y}) - $signed({r_min_y[CW-1], r_min_y});

    always_comb begin
        if (r_bad) begin
            w_err = hlc_pkg::ST_BAD_SIZE;
        end else if (r_ovf) begin
            w_err = hlc_pkg::ST_OVERFLOW;
        end else begin
            w_err = hlc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_pt.x   <= i_item.point_x;
            r_pt.y   <= i_item.point_y;
            r_pt.z   <= i_item.point_z;
            r_last   <= i_item.last_point;
            r_do_asp <= r_asp_en && (w_maxdim != '0);
            r_bad    <= r_asp_en && (w_maxdim == '0);
        end else if (w_done && r_sel == hlc_pkg::DS_ASP_X) begin
            r_pt.x <= w_a_sat;
        end else if (w_done && r_sel == hlc_pkg::DS_ASP_Y) begin
            r_pt.y <= w_a_sat;
        end
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
        end
        if (w_done && r_sel == hlc_pkg::DS_OUT_X) begin
            r_nx <= w_q_sat;
        end
        if (w_done && r_sel == hlc_pkg::DS_OUT_Y) begin
            r_ny <= w_q_sat;
        end
        if (i_cmd.latch_scale) begin
            r_scale <= DW'((w_rx > w_ry) ? w_rx : w_ry) + DW'(hlc_pkg::EPS);
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pt && r_cnt < CNT_W'(MAX_POINTS)) begin
            r_mem[r_cnt[AW-1:0]] <= w_diff;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_hand) begin
            r_wrist <= '0;
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.store_pt) begin
                if (r_cnt < CNT_W'(MAX_POINTS)) begin
                    r_wrist <= w_wr;
                    r_cnt   <= r_cnt + 1'b1;
                    if (w_diff.x < r_min_x) r_min_x <= w_diff.x;
                    if (w_diff.x > r_max_x) r_max_x <= w_diff.x;
                    if (w_diff.y < r_min_y) r_min_y <= w_diff.y;
                    if (w_diff.y > r_max_y) r_max_y <= w_diff.y;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_ok || i_cmd.load_err) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out.norm_x      <= '0;
            r_out.norm_y      <= '0;
            r_out.norm_z      <= '0;
            r_out.end_of_hand <= 1'b1;
            r_out.status      <= w_err;
        end else if (i_cmd.load_ok) begin
            r_out.norm_x      <= r_nx;
            r_out.norm_y      <= r_ny;
            r_out.norm_z      <= w_q_sat;
            r_out.end_of_hand <= (r_idx == r_cnt - 1'b1);
            r_out.status      <= hlc_pkg::ST_OK;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_comb begin
        o_sts.do_aspect = r_do_asp;
        o_sts.last      = r_last;
        o_sts.div_done  = w_done;
        o_sts.err       = w_err;
        o_sts.emit_last = (r_idx == r_cnt - 1'b1);
        o_sts.out_free  = !r_ov || i_out_ready;
    end
endmodule

[hdl/hand_landmark_canonicalizer_unit.sv]
// Hand landmark canonicalizer: top level joining sequencer and datapath.
// Depends on hlc_pkg, hlc_stream_if, hlc_ctrl, hlc_datapath.
//
// Usage:
//   i_pt takes one landmark point (x, y, z in signed Q3.16) per item, last_point
//   marking the final point of a hand. o_res gives one item per stored point
//   once the last point is in, in arrival order, end_of_hand on the final one;
//   an invalid image size or too many points gives a single status item instead.
//   Configuration (aspect enable, width, height) is written on i_cfg_* while idle.
// Timing:
//   The one shared divider yields one quotient bit per cycle. Intake captures a
//   point and stores it, with two divides (x, then y) between when aspect
//   correction is on. After the last point each result takes a read of the point
//   store and three divides (x, y, z); an error item is loaded instead once the
//   output register is free. One item is in work at a time: i_pt.ready is low
//   from acceptance until the item (or the hand's whole emission) is done.
// Reset: synchronous active low; clears control, hand state and config defaults.
// Stall: a result waits in the output register; the next result is worked out
//   meanwhile and held until the register is free. Nothing is dropped.
module hand_landmark_canonicalizer_unit #(
    parameter int MAX_POINTS = hlc_pkg::MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [hlc_pkg::DIM_W-1:0] i_cfg_wdata,
    hlc_stream_if.sink                i_pt,
    hlc_stream_if.source              o_res
);
    hlc_pkg::t_cmd w_cmd;
    hlc_pkg::t_sts w_sts;

    hlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (i_pt.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hlc_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_pt.data),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_out_item  (o_res.data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );
endmodule

[hdl/hlc_checker.sv]
// Port-level checks of the canonicalizer, bound to the top level.
// Depends on hlc_pkg and hand_landmark_canonicalizer_unit.
module hlc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input hlc_pkg::t_out_item        out_item
);
    logic w_in_acc;
    assign w_in_acc = in_valid && in_ready;

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !in_ready)
        else $error("ready held right after an accepted item");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(out_valid))
        else $error("result appeared one cycle after an item");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_item.status != hlc_pkg::ST_OK |->
            out_item.end_of_hand && out_item.norm_x == '0 &&
            out_item.norm_y == '0 && out_item.norm_z == '0)
        else $error("error item not terminal or not zeroed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind hand_landmark_canonicalizer_unit hlc_checker u_hlc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_pt.valid),
    .in_ready  (i_pt.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_item  (o_res.data)
);

[tb/hand_landmark_canonicalizer_unit_tb.sv]
// Self-checking testbench for hand_landmark_canonicalizer_unit.
// Depends on hlc_pkg, hlc_stream_if and the RTL of the unit.
`timescale 1ns / 100ps

module hand_landmark_canonicalizer_unit_tb;

    typedef logic signed [hlc_pkg::COORD_W-1:0] t_coord;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [hlc_pkg::DIM_W-1:0] i_cfg_wdata;

    hlc_stream_if #(.T(hlc_pkg::t_in_item))  pt_if  (.i_clk(i_clk));
    hlc_stream_if #(.T(hlc_pkg::t_out_item)) res_if (.i_clk(i_clk));

    hand_landmark_canonicalizer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pt        (pt_if.sink),
        .o_res       (res_if.source)
    );

    // shadow of the configuration and of the hand state
    logic        asp_en;
    int          img_w, img_h;
    int          hand_pts [hlc_pkg::MAX_POINTS_DEF][3];
    int          wrist [3];
    int          min_x, max_x, min_y, max_y;
    int          n_pts;
    bit          ovf;

    hlc_pkg::t_out_item expected_results [$];
    int          n_errors;
    int          n_results;
    int          n_items;
    int          n_hands;
    bit          idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[hand_landmark_canonicalizer_unit] ERROR");
        $finish;
    end

    function automatic int sat20(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return int'(v);
    endfunction

    function automatic int aspect_corr(int c, int dim, int maxdim);
        longint d;
        d = longint'(c) - 32768;
        // SV division truncates toward zero, like the hardware
        return sat20((d * dim) / maxdim + 32768);
    endfunction

    task automatic clear_hand_state();
        wrist = '{0, 0, 0};
        min_x = 0; max_x = 0; min_y = 0; max_y = 0;
        n_pts = 0;
        ovf = 0;
    endtask

    // expected results of one landmark point
    task automatic predict_point(hlc_pkg::t_in_item it);
        int c [3];
        int d [3];
        int maxdim;
        longint sc;
        longint rx, ry;
        hlc_pkg::t_out_item r;
        c[0] = it.point_x; c[1] = it.point_y; c[2] = it.point_z;
        maxdim = (img_w > img_h) ? img_w : img_h;
        if (asp_en && maxdim > 0) begin
            c[0] = aspect_corr(c[0], img_w, maxdim);
            c[1] = aspect_corr(c[1], img_h, maxdim);
        end
        if (n_pts == 0) wrist = c;
        if (n_pts < hlc_pkg::MAX_POINTS_DEF) begin
            for (int k = 0; k < 3; k++) begin
                d[k] = sat20(longint'(c[k]) - wrist[k]);
                hand_pts[n_pts][k] = d[k];
            end
            if (d[0] < min_x) min_x = d[0];
            if (d[0] > max_x) max_x = d[0];
            if (d[1] < min_y) min_y = d[1];
            if (d[1] > max_y) max_y = d[1];
            n_pts++;
        end else begin
            ovf = 1;
        end
        if (!it.last_point) return;
        n_hands++;
        if ((asp_en && maxdim == 0) || ovf) begin
            r = '0;
            r.end_of_hand = 1'b1;
            r.status = (asp_en && maxdim == 0) ? hlc_pkg::ST_BAD_SIZE : hlc_pkg::ST_OVERFLOW;
            expected_results.push_back(r);
        end else begin
            rx = longint'(max_x) - min_x;
            ry = longint'(max_y) - min_y;
            sc = ((rx > ry) ? rx : ry) + hlc_pkg::EPS;
            for (int i = 0; i < n_pts; i++) begin
                r.norm_x = t_coord'(sat20((longint'(hand_pts[i][0]) <<< 16) / sc));
                r.norm_y = t_coord'(sat20((longint'(hand_pts[i][1]) <<< 16) / sc));
                r.norm_z = t_coord'(sat20((longint'(hand_pts[i][2]) <<< 16) / sc));
                r.end_of_hand = (i + 1 == n_pts);
                r.status = hlc_pkg::ST_OK;
                expected_results.push_back(r);
            end
        end
        clear_hand_state();
    endtask

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
    endtask

    // result checker with random receive stalls
    initial begin
        int stall;
        hlc_pkg::t_out_item want;
        res_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 7);
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.data.norm_x !== want.norm_x)
                        report_mismatch("norm_x", res_if.data.norm_x, want.norm_x);
                    if (res_if.data.norm_y !== want.norm_y)
                        report_mismatch("norm_y", res_if.data.norm_y, want.norm_y);
                    if (res_if.data.norm_z !== want.norm_z)
                        report_mismatch("norm_z", res_if.data.norm_z, want.norm_z);
                    if (res_if.data.end_of_hand !== want.end_of_hand)
                        report_mismatch("end_of_hand", res_if.data.end_of_hand,
                                        want.end_of_hand);
                    if (res_if.data.status !== want.status)
                        report_mismatch("status", res_if.data.status, want.status);
                end
            end
        end
    end

    // valid stays up between back-to-back items; wait_drained drops it
    task automatic send_point(int x, int y, int z, bit last);
        hlc_pkg::t_in_item it;
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.point_x = t_coord'(x);
        it.point_y = t_coord'(y);
        it.point_z = t_coord'(z);
        it.last_point = last;
        pt_if.valid <= 1'b1;
        pt_if.data  <= it;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        predict_point(it);
        n_items++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        pt_if.valid <= 1'b0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(hlc_pkg::t_cfg_idx idx, int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= hlc_pkg::DIM_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            hlc_pkg::CFG_ASPECT_EN: asp_en = value[0];
            hlc_pkg::CFG_IMG_W:     img_w = value & 16'hFFFF;
            hlc_pkg::CFG_IMG_H:     img_h = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    function automatic int rnd_coord();
        case ($urandom_range(0, 5))
            0:       return -524288;
            1:       return 524287;
            2:       return $signed(20'($urandom));
            default: return $urandom_range(0, 131072) - 65536;
        endcase
    endfunction

    task automatic send_hand(int n);
        for (int i = 0; i < n; i++)
            send_point(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
    endtask

    task automatic test_extremes();
        send_point(0, 0, 0, 1'b1);
        send_point(-524288, 524287, -524288, 1'b0);
        send_point(524287, -524288, 524287, 1'b0);
        send_point(0, 0, 0, 1'b1);
        send_point(65536, 0, 0, 1'b0);
        send_point(-65536, 32768, 1, 1'b0);
        send_point(12345, -777, -1, 1'b1);
        wait_drained();
    endtask

    task automatic test_aspect();
        write_cfg(hlc_pkg::CFG_ASPECT_EN, 1);
        write_cfg(hlc_pkg::CFG_IMG_W, 640);
        write_cfg(hlc_pkg::CFG_IMG_H, 480);
        send_point(30000, 40000, 5, 1'b0);
        send_point(-524288, 524287, 0, 1'b1);
        wait_drained();
        write_cfg(hlc_pkg::CFG_IMG_W, 65535);
        write_cfg(hlc_pkg::CFG_IMG_H, 0);
        send_point(100, 524287, 3, 1'b0);
        send_point(-524288, 9, 3, 1'b1);
        wait_drained();
    endtask

    task automatic test_bad_size();
        write_cfg(hlc_pkg::CFG_IMG_W, 0);
        send_point(1000, 2000, 3000, 1'b0);
        send_point(-1000, 2, 3, 1'b1);
        wait_drained();
    endtask

    task automatic test_overflow();
        write_cfg(hlc_pkg::CFG_ASPECT_EN, 0);
        write_cfg(hlc_pkg::CFG_IMG_W, 1);
        write_cfg(hlc_pkg::CFG_IMG_H, 1);
        send_hand(hlc_pkg::MAX_POINTS_DEF);
        wait_drained();
        send_hand(hlc_pkg::MAX_POINTS_DEF + 2);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        for (int h = 0; h < 3; h++) begin
            if (h == 2) idle_on = 0;
            case ($urandom_range(0, 3))
                0: write_cfg(hlc_pkg::CFG_ASPECT_EN, 0);
                1: write_cfg(hlc_pkg::CFG_ASPECT_EN, 1);
                default: ;
            endcase
            write_cfg(hlc_pkg::CFG_IMG_W,
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 65535));
            write_cfg(hlc_pkg::CFG_IMG_H,
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 65535));
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 34) : $urandom_range(10, 16);
            send_hand(n);
            wait_drained();
        end
    endtask

    initial begin
        n_errors = 0; n_results = 0; n_items = 0; n_hands = 0;
        idle_on = 1;
        asp_en = 0; img_w = 1; img_h = 1;
        clear_hand_state();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= hlc_pkg::CFG_NONE;
        i_cfg_wdata <= '0;
        pt_if.valid <= 1'b0;
        pt_if.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_aspect();
        test_bad_size();
        test_overflow();
        test_random();
        wait_drained();

        $display("covered %0d points in %0d hands, %0d results checked",
                 n_items, n_hands, n_results);
        $display("aspect on/off, zero image sizes and point overflow included");
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("[hand_landmark_canonicalizer_unit] OK");
        end else begin
            $display("[hand_landmark_canonicalizer_unit] ERROR");
        end
        $finish;
    end
endmodule
